// File: design/lftl_pkg.sv
// ----------------------------------------------------------------------------
// Level frame package
// Types, constants and register indexes shared by the level frame converter.
// ----------------------------------------------------------------------------
package lftl_pkg;

    localparam int unsigned LEVEL_W      = 16;
    localparam int unsigned SCALE_W      = 20;
    localparam int unsigned FLIMIT_W     = 8;
    localparam int unsigned DLIMIT_W     = 7;
    localparam int unsigned PROD_W       = LEVEL_W + SCALE_W;
    localparam int unsigned LITRES_W     = 5;
    localparam int unsigned VALUE_W      = 7;
    localparam int unsigned RANK_W       = 8;
    localparam int unsigned DIR_W        = 8;
    localparam int unsigned CFG_IDX_W    = 2;

    localparam logic [7:0]          FRAME_HEADER  = 8'hFF;
    localparam logic [2:0]          FRAME_GOOD_LEN = 3'd4;
    localparam int unsigned         LitresMax     = 20;
    localparam int unsigned         Divisor       = 1000000;
    localparam logic [VALUE_W-1:0]  POWER_ON_VALUE = 7'd88;
    localparam logic [RANK_W-1:0]   FAULT_RANK    = 8'd128;

    localparam logic [SCALE_W-1:0]  SCALE_RESET   = 20'd70686;
    localparam logic [FLIMIT_W-1:0] FLIMIT_RESET  = 8'd3;
    localparam logic [DLIMIT_W-1:0] DLIMIT_RESET  = 7'd3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LITRES_SCALE    = 2'd0,
        CFG_FAULT_LIMIT     = 2'd1,
        CFG_DIRECTION_LIMIT = 2'd2,
        CFG_UNUSED          = 2'd3
    } t_cfg_index;

    typedef struct packed {
        logic [2:0] frame_len;
        logic [7:0] byte_zero;
        logic [7:0] byte_one;
        logic [7:0] byte_two;
        logic [7:0] byte_three;
    } t_in_item;

    typedef struct packed {
        logic [LITRES_W-1:0] capacity_litres;
        logic                sensor_fault;
    } t_out_item;

    typedef struct packed {
        logic               good;
        logic [LEVEL_W-1:0] level;
    } t_cls_item;

    typedef struct packed {
        logic [SCALE_W-1:0]  litres_scale;
        logic [FLIMIT_W-1:0] fault_limit;
        logic [DLIMIT_W-1:0] direction_limit;
    } t_cfg;

endpackage

// File: design/lftl_front.sv
// ----------------------------------------------------------------------------
// Level frame front end
// Accepts received frames, checks length, header and checksum, and passes a
// classified item with its level on towards the queue.
// ----------------------------------------------------------------------------
module lftl_front import lftl_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_item,
    output logic      o_push,
    output t_cls_item o_cls_item,
    input  logic      i_q_ready
);

    logic      r_valid;
    t_cls_item r_item;
    t_cls_item n_item;
    logic [7:0] sum_low;

    always_comb begin
        sum_low = i_in_item.byte_zero + i_in_item.byte_one + i_in_item.byte_two;
        n_item.good  = (i_in_item.frame_len == FRAME_GOOD_LEN) &&
                       (i_in_item.byte_zero == FRAME_HEADER) &&
                       (sum_low == i_in_item.byte_three);
        n_item.level = {i_in_item.byte_one, i_in_item.byte_two};
    end

    assign o_in_ready = !r_valid || i_q_ready;
    assign o_push     = r_valid && i_q_ready;
    assign o_cls_item = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_valid <= i_in_valid;
        end
        if (i_in_valid && o_in_ready) begin
            r_item <= n_item;
        end
    end

endmodule

// File: design/lftl_queue.sv
// ----------------------------------------------------------------------------
// Level frame queue
// Two-entry queue of classified frames between the front and back ends.
// ----------------------------------------------------------------------------
module lftl_queue import lftl_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_cls_item i_item,
    output logic      o_ready,
    output logic      o_valid,
    output t_cls_item o_item,
    input  logic      i_pop
);

    t_cls_item  r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       do_pop;

    assign o_valid = (r_count != 2'd0);
    assign do_pop  = i_pop && o_valid;
    assign o_ready = (r_count != 2'd2) || do_pop;
    assign o_item  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (do_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            unique case ({i_push, do_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

// File: design/lftl_back.sv
// ----------------------------------------------------------------------------
// Level frame back end
// Scales the level to whole litres, tracks bad frames and debounces the
// reported value, and holds each report in an output register.
// ----------------------------------------------------------------------------
module lftl_back import lftl_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cfg      i_cfg,
    input  logic      i_q_valid,
    input  t_cls_item i_q_item,
    output logic      o_pop,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_item
);

    logic                r_s1_valid;
    logic                r_s1_good;
    logic [PROD_W-1:0]   r_s1_prod;
    logic                r_s2_valid;
    logic                r_s2_good;
    logic [LITRES_W-1:0] r_s2_litres;
    logic                r_out_valid;
    t_out_item           r_out_item;

    logic [VALUE_W-1:0]  r_rep_value;
    logic                r_rep_fault;
    logic [VALUE_W-1:0]  r_cand_value;
    logic                r_cand_fault;
    logic [DIR_W-1:0]    r_dir;
    logic [FLIMIT_W-1:0] r_bad;

    logic                s2_fire;
    logic                s2_en;
    logic                s1_en;
    logic [LITRES_W-1:0] n_litres;
    logic [PROD_W-1:0]   thr;
    logic [FLIMIT_W-1:0] bad_inc;
    logic [VALUE_W-1:0]  n_cand_value;
    logic                n_cand_fault;
    logic [FLIMIT_W-1:0] n_bad;
    logic [RANK_W-1:0]   rank_c;
    logic [RANK_W-1:0]   rank_r;
    logic [DIR_W-1:0]    dir_step;
    logic [DIR_W:0]      lim_pos;
    logic [DIR_W:0]      lim_neg;
    logic                report;

    assign s2_fire = r_s2_valid && (!r_out_valid || i_out_ready);
    assign s2_en   = !r_s2_valid || s2_fire;
    assign s1_en   = !r_s1_valid || s2_en;
    assign o_pop   = s1_en && i_q_valid;

    // Round half up of product over one million, saturating at the maximum.
    always_comb begin
        n_litres = '0;
        thr      = '0;
        for (int k = 1; k <= LitresMax; k++) begin
            thr = PROD_W'(k * Divisor - Divisor / 2);
            if (r_s1_prod >= thr) begin
                n_litres = LITRES_W'(k);
            end
        end
    end

    always_comb begin
        bad_inc = r_bad + 8'd1;
        if (r_s2_good) begin
            n_bad        = '0;
            n_cand_value = VALUE_W'(r_s2_litres);
            n_cand_fault = 1'b0;
        end else if (bad_inc >= i_cfg.fault_limit) begin
            n_bad        = '0;
            n_cand_value = '0;
            n_cand_fault = 1'b1;
        end else begin
            n_bad        = bad_inc;
            n_cand_value = r_cand_value;
            n_cand_fault = r_cand_fault;
        end
        rank_c   = n_cand_fault ? FAULT_RANK : RANK_W'(n_cand_value);
        rank_r   = r_rep_fault  ? FAULT_RANK : RANK_W'(r_rep_value);
        dir_step = (rank_c > rank_r) ? r_dir + 8'd1 : r_dir - 8'd1;
        lim_pos  = (DIR_W + 1)'(i_cfg.direction_limit);
        lim_neg  = -lim_pos;
        report   = (rank_c != rank_r) &&
                   (($signed({dir_step[DIR_W-1], dir_step}) > $signed(lim_pos)) ||
                    ($signed({dir_step[DIR_W-1], dir_step}) < $signed(lim_neg)));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid   <= 1'b0;
            r_s2_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_rep_value  <= POWER_ON_VALUE;
            r_rep_fault  <= 1'b0;
            r_cand_value <= POWER_ON_VALUE;
            r_cand_fault <= 1'b0;
            r_dir        <= '0;
            r_bad        <= '0;
        end else begin
            if (s1_en) begin
                r_s1_valid <= i_q_valid;
            end
            if (s2_en) begin
                r_s2_valid <= r_s1_valid;
            end
            if (s2_fire) begin
                r_out_valid  <= report;
                r_bad        <= n_bad;
                r_cand_value <= n_cand_value;
                r_cand_fault <= n_cand_fault;
                if (report) begin
                    r_rep_value <= n_cand_value;
                    r_rep_fault <= n_cand_fault;
                    r_dir       <= '0;
                end else if (rank_c != rank_r) begin
                    r_dir <= dir_step;
                end
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (o_pop) begin
            r_s1_good <= i_q_item.good;
            r_s1_prod <= PROD_W'(i_q_item.level) * PROD_W'(i_cfg.litres_scale);
        end
        if (s2_en && r_s1_valid) begin
            r_s2_good   <= r_s1_good;
            r_s2_litres <= n_litres;
        end
        if (s2_fire && report) begin
            r_out_item.capacity_litres <= n_cand_fault ? '0 : n_cand_value[LITRES_W-1:0];
            r_out_item.sensor_fault    <= n_cand_fault;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

// File: design/level_frame_to_litres_debounce.sv
// ----------------------------------------------------------------------------
// Level frame to litres with debounce
// Converts level sensor frames to whole litres, declares a sensor fault after
// a run of bad frames and reports a new value only after debouncing.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake                   Payload
//  in        input      i_in_valid / o_in_ready     i_in_item  (t_in_item)
//  out       output     o_out_valid / i_out_ready   o_out_item (t_out_item)
//  cfg       input      i_cfg_valid / o_cfg_ready   i_cfg_index, i_cfg_data
//
// One frame is accepted every cycle when the output is not stalled; the
// bound is the state update in the back end. A report passes through the
// front register, the queue, back-end stages s1 and s2 and the output
// register. Synchronous reset restores the registers to their reset values
// and empties the pipeline. A stalled output fills the back end, the queue
// and the front register, and then drops the input ready.
// ----------------------------------------------------------------------------
module level_frame_to_litres_debounce import lftl_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  t_in_item             i_in_item,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output t_out_item            o_out_item,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [SCALE_W-1:0]   i_cfg_data
);

    t_cfg      r_cfg;
    logic      push;
    t_cls_item front_item;
    logic      q_ready;
    logic      q_valid;
    t_cls_item q_item;
    logic      pop;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.litres_scale    <= SCALE_RESET;
            r_cfg.fault_limit     <= FLIMIT_RESET;
            r_cfg.direction_limit <= DLIMIT_RESET;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_LITRES_SCALE:    r_cfg.litres_scale    <= i_cfg_data;
                CFG_FAULT_LIMIT:     r_cfg.fault_limit     <= i_cfg_data[FLIMIT_W-1:0];
                CFG_DIRECTION_LIMIT: r_cfg.direction_limit <= i_cfg_data[DLIMIT_W-1:0];
                default:             r_cfg                 <= r_cfg;
            endcase
        end
    end

    lftl_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_item  (i_in_item),
        .o_push     (push),
        .o_cls_item (front_item),
        .i_q_ready  (q_ready)
    );

    lftl_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (front_item),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .o_item  (q_item),
        .i_pop   (pop)
    );

    lftl_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_q_valid   (q_valid),
        .i_q_item    (q_item),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

endmodule

// File: tb/level_report_check_pkg.sv
// ----------------------------------------------------------------------------
// Level report checker
// Tracks the litres a level frame stream should report and checks the
// reports that the converter hands out, oldest first.
// ----------------------------------------------------------------------------
package level_report_check_pkg;

    import lftl_pkg::*;

    class litres_report_tracker;

        logic [SCALE_W-1:0]  scale;
        logic [FLIMIT_W-1:0] fault_lim;
        logic [DLIMIT_W-1:0] dir_lim;

        logic [VALUE_W-1:0]  shown_value;
        logic                shown_fault;
        logic [VALUE_W-1:0]  next_value;
        logic                next_fault;
        logic [DIR_W-1:0]    swing;
        logic [7:0]          bad_run;

        t_out_item           due_reports[$];
        int unsigned         mismatches;

        function new();
            scale       = SCALE_RESET;
            fault_lim   = FLIMIT_RESET;
            dir_lim     = DLIMIT_RESET;
            shown_value = POWER_ON_VALUE;
            shown_fault = 1'b0;
            next_value  = POWER_ON_VALUE;
            next_fault  = 1'b0;
            swing       = '0;
            bad_run     = '0;
            mismatches  = 0;
        endfunction

        function void set_register(t_cfg_index idx, logic [SCALE_W-1:0] data);
            case (idx)
                CFG_LITRES_SCALE:    scale     = data;
                CFG_FAULT_LIMIT:     fault_lim = data[FLIMIT_W-1:0];
                CFG_DIRECTION_LIMIT: dir_lim   = data[DLIMIT_W-1:0];
                default: ;
            endcase
        endfunction

        function logic [VALUE_W-1:0] litres_for(logic [LEVEL_W-1:0] level);
            longint unsigned prod;
            prod = longint'(level) * longint'(scale);
            if (prod > longint'(LitresMax) * longint'(Divisor)) begin
                return VALUE_W'(LitresMax);
            end
            return VALUE_W'((prod + Divisor / 2) / Divisor);
        endfunction

        function void note_frame(t_in_item f);
            logic [7:0]        sum;
            logic              good;
            logic [RANK_W-1:0] rank_next;
            logic [RANK_W-1:0] rank_shown;
            int                dir;
            int                lim;
            t_out_item         rep;
            sum  = f.byte_zero + f.byte_one + f.byte_two;
            good = (f.frame_len == FRAME_GOOD_LEN) && (f.byte_zero == FRAME_HEADER)
                   && (sum == f.byte_three);
            if (!good) begin
                bad_run = bad_run + 8'd1;
                if (bad_run >= fault_lim) begin
                    bad_run    = '0;
                    next_value = '0;
                    next_fault = 1'b1;
                end
            end else begin
                bad_run    = '0;
                next_value = litres_for({f.byte_one, f.byte_two});
                next_fault = 1'b0;
            end
            rank_next  = next_fault ? FAULT_RANK : RANK_W'(next_value);
            rank_shown = shown_fault ? FAULT_RANK : RANK_W'(shown_value);
            if (rank_next == rank_shown) begin
                return;
            end
            swing = (rank_next > rank_shown) ? swing + 8'd1 : swing - 8'd1;
            dir   = $signed(swing);
            lim   = int'(dir_lim);
            if (dir > lim || dir < -lim) begin
                shown_value         = next_value;
                shown_fault         = next_fault;
                swing               = '0;
                rep.capacity_litres = shown_fault ? '0 : shown_value[LITRES_W-1:0];
                rep.sensor_fault    = shown_fault;
                due_reports.push_back(rep);
            end
        endfunction

        task flag(string msg);
            $display("MISMATCH at %0t: %s", $time, msg);
            mismatches++;
        endtask

        task check_report(t_out_item got);
            t_out_item want;
            if (due_reports.size() == 0) begin
                flag($sformatf("unexpected report litres=%0d fault=%0b",
                               got.capacity_litres, got.sensor_fault));
                return;
            end
            want = due_reports.pop_front();
            if (got.capacity_litres !== want.capacity_litres) begin
                flag($sformatf("capacity_litres got %0d want %0d",
                               got.capacity_litres, want.capacity_litres));
            end
            if (got.sensor_fault !== want.sensor_fault) begin
                flag($sformatf("sensor_fault got %0b want %0b",
                               got.sensor_fault, want.sensor_fault));
            end
        endtask

    endclass

endpackage

// File: tb/tb_level_frame_to_litres_debounce.sv
// ----------------------------------------------------------------------------
// Level frame to litres testbench
// Drives directed and random sensor frames through the converter under
// several register settings and idling patterns, and checks every report
// against a running prediction of the debounced litres value.
// ----------------------------------------------------------------------------
module tb_level_frame_to_litres_debounce;

    timeunit 1ns;
    timeprecision 1ps;

    import lftl_pkg::*;
    import level_report_check_pkg::*;

    localparam int CLK_PERIOD    = 20;
    localparam int SETTLE_CYCLES = 16;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int PHASE_ITEMS   = 306;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_ready;
    t_in_item             i_in_item;
    logic                 o_out_valid;
    logic                 i_out_ready;
    t_out_item            o_out_item;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [SCALE_W-1:0]   i_cfg_data;

    litres_report_tracker tracker;
    int unsigned          sender_idle_pct;
    int unsigned          receiver_stall_pct;
    int unsigned          cycle_count;
    logic [LEVEL_W-1:0]   hold_level;
    int                   hold_left;
    int                   bad_left;

    level_frame_to_litres_debounce dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    initial begin
        cycle_count = 0;
        forever begin
            @(posedge i_clk);
            cycle_count++;
            if (cycle_count >= CYCLE_LIMIT) begin
                $display("tb_level_frame_to_litres_debounce: FAIL");
                $finish;
            end
        end
    end

    initial begin
        i_out_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && i_out_ready) begin
                tracker.check_report(o_out_item);
            end
            i_out_ready <= ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    function automatic t_in_item good_frame(logic [LEVEL_W-1:0] level);
        t_in_item f;
        f.frame_len  = FRAME_GOOD_LEN;
        f.byte_zero  = FRAME_HEADER;
        f.byte_one   = level[15:8];
        f.byte_two   = level[7:0];
        f.byte_three = FRAME_HEADER + level[15:8] + level[7:0];
        return f;
    endfunction

    function automatic t_in_item noise_frame();
        logic [63:0] bits;
        t_in_item    f;
        bits = {$urandom, $urandom};
        f    = bits[$bits(t_in_item)-1:0];
        return f;
    endfunction

    function automatic t_in_item bad_frame();
        t_in_item   f;
        logic [2:0] len;
        f = good_frame(LEVEL_W'($urandom_range(0, 65535)));
        case ($urandom_range(3))
            0: begin
                len = 3'($urandom_range(0, 6));
                if (len >= FRAME_GOOD_LEN) begin
                    len = len + 3'd1;
                end
                f.frame_len = len;
            end
            1: f.byte_zero  = 8'($urandom_range(0, 254));
            2: f.byte_three = f.byte_three + 8'($urandom_range(1, 255));
            default: f = noise_frame();
        endcase
        return f;
    endfunction

    // Mostly runs of one level, some held long enough to pass the debounce, broken by
    // bursts of bad frames that may or may not reach the fault limit.
    function t_in_item random_frame();
        int unsigned pick;
        pick = $urandom_range(99);
        if (bad_left == 0 && pick < 3) begin
            bad_left = $urandom_range(1, int'(tracker.fault_lim) + 1);
        end
        if (bad_left > 0) begin
            bad_left--;
            return bad_frame();
        end
        if (pick >= 93) begin
            return noise_frame();
        end
        if (hold_left == 0) begin
            case ($urandom_range(3))
                0: hold_level = LEVEL_W'($urandom_range(0, 65535));
                1: hold_level = LEVEL_W'($urandom_range(0, 255));
                2: hold_level = LEVEL_W'($urandom_range(0, 4095));
                default: hold_level = $urandom_range(1) ? 16'hFFFF : 16'h0000;
            endcase
            hold_left = $urandom_range(1, int'(tracker.dir_lim) + 4);
        end
        hold_left--;
        return good_frame(hold_level);
    endfunction

    task send_frame(t_in_item f);
        if ($urandom_range(99) < sender_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < sender_idle_pct);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= f;
        do @(posedge i_clk); while (!o_in_ready);
        tracker.note_frame(f);
    endtask

    task write_register(t_cfg_index idx, logic [SCALE_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        tracker.set_register(idx, data);
    endtask

    task configure(logic [SCALE_W-1:0] scale, logic [FLIMIT_W-1:0] flim,
                   logic [DLIMIT_W-1:0] dlim, logic poke_unused);
        write_register(CFG_LITRES_SCALE, scale);
        write_register(CFG_FAULT_LIMIT, SCALE_W'(flim));
        write_register(CFG_DIRECTION_LIMIT, SCALE_W'(dlim));
        if (poke_unused) begin
            write_register(CFG_UNUSED, SCALE_W'($urandom_range(0, 1048575)));
        end
        i_cfg_valid <= 1'b0;
    endtask

    task drain();
        i_in_valid <= 1'b0;
        while (tracker.due_reports.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        t_in_item f;
        tracker            = new();
        sender_idle_pct    = 33;
        receiver_stall_pct = 59;
        hold_left          = 0;
        bad_left           = 0;
        hold_level         = '0;
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_in_item   <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= CFG_LITRES_SCALE;
        i_cfg_data  <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings: drop to empty, climb to full, then a fault run made
        // of every kind of bad frame, which outranks any litres value.
        repeat (4) send_frame(good_frame(16'h0000));
        repeat (4) send_frame(good_frame(16'hFFFF));
        send_frame({3'd0, 8'h00, 8'h00, 8'h00, 8'h00});
        f = good_frame(16'h1234);
        f.frame_len = 3'd5;
        send_frame(f);
        f.frame_len = 3'd7;
        send_frame(f);
        f = good_frame(16'h0A0B);
        f.byte_zero = 8'hFE;
        send_frame(f);
        f = good_frame(16'h0A0B);
        f.byte_three ^= 8'h01;
        send_frame(f);
        send_frame({3'd3, 8'hFF, 8'hFF, 8'hFF, 8'hFF});
        drain();

        // Half a litre per level step: rounding half up, the clamp, and a fault
        // declared by the very first bad frame.
        configure(20'd500000, 8'd0, 7'd0, 1'b0);
        send_frame(good_frame(16'd1));
        send_frame(good_frame(16'd40));
        send_frame(good_frame(16'd41));
        send_frame(good_frame(16'd3));
        f = good_frame(16'h5555);
        f.byte_three ^= 8'h80;
        send_frame(f);
        send_frame(good_frame(16'd0));
        send_frame(good_frame(16'h8000));
        drain();

        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0: configure(20'hFFFFF, 8'd1, 7'd0, 1'b0);
                1: configure(20'd0, 8'd255, 7'd1, 1'b0);
                2: configure(SCALE_W'($urandom_range(100, 2000)), 8'd3, 7'd3, 1'b1);
                3: configure(SCALE_W'($urandom_range(100, 2000)),
                             FLIMIT_W'($urandom_range(1, 8)), 7'd100, 1'b0);
                4: configure(SCALE_W'($urandom_range(100, 2000)), 8'd5, 7'd127, 1'b0);
                default: configure(SCALE_W'($urandom_range(0, 1048575)), 8'd0,
                                   DLIMIT_W'($urandom_range(0, 6)), 1'b0);
            endcase
            if (phase < 2) begin
                sender_idle_pct    = 33;
                receiver_stall_pct = 59;
            end else if (phase < 4) begin
                sender_idle_pct    = 59;
                receiver_stall_pct = 33;
            end else begin
                sender_idle_pct    = 0;
                receiver_stall_pct = 0;
            end
            hold_left = 0;
            bad_left  = 0;
            repeat (PHASE_ITEMS) send_frame(random_frame());
            drain();
        end

        if (tracker.mismatches == 0) begin
            $display("tb_level_frame_to_litres_debounce: PASS");
        end else begin
            $display("tb_level_frame_to_litres_debounce: FAIL");
        end
        $finish;
    end

endmodule

// File: files.f
design/lftl_pkg.sv
design/lftl_front.sv
design/lftl_queue.sv
design/lftl_back.sv
design/level_frame_to_litres_debounce.sv
tb/level_report_check_pkg.sv
tb/tb_level_frame_to_litres_debounce.sv
